// ----- hw/rtl/key_combo_sequence_detector_defines.svh -----
// Assertion helpers for the detector's checks on its own logic.
`ifndef KEY_COMBO_SEQUENCE_DETECTOR_DEFINES_SVH
`define KEY_COMBO_SEQUENCE_DETECTOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KCSD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define KCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/kcsd_pkg.sv -----
`timescale 1ns / 1ps

package kcsd_pkg;

   // Sizes of the configured sequences and of the hold countdown
   localparam int COMBO_MAX  = 6;
   localparam int ROTARY_MAX = 5;
   localparam int TIMER_BITS = 16;

   // Field widths
   localparam int CODE_W       = 10;
   localparam int POS_W        = 3;
   localparam int VALUE_W      = 16;
   localparam int ENTRY_W      = CODE_W + 1;
   localparam int HOLD_TICKS_W = 16;
   localparam int HOLD_VALUE_W = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   // Reset values and fixed codes
   localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RESET = HOLD_TICKS_W'(5000);
   localparam logic [CODE_W-1:0]       POWER_KEY_CODE   = CODE_W'(116);
   localparam logic [CODE_W-1:0]       AXIS_X           = CODE_W'(0);
   localparam logic [31:0]             TIMER_LIMIT      = 32'((64'd1 << TIMER_BITS) - 64'd1);

   typedef enum logic [1:0] {
      ACT_KEY   = 2'd0,
      ACT_REL   = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_OTHER = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMBO_CODES    = 3'd0,
      CSR_COMBO_LENGTH   = 3'd1,
      CSR_ROTARY_ENTRIES = 3'd2,
      CSR_ROTARY_LENGTH  = 3'd3,
      CSR_HOLD_KEY_CODE  = 3'd4,
      CSR_HOLD_KEY_VALUE = 3'd5,
      CSR_HOLD_TICKS     = 3'd6,
      CSR_COUNT_REPEATS  = 3'd7
   } csr_index_type;

   typedef enum logic {
      KIND_KEY = 1'b0,
      KIND_REL = 1'b1
   } entry_kind_type;

   // Rotary sequence setup with the length already clamped
   typedef struct packed {
      logic [ROTARY_MAX-1:0][ENTRY_W-1:0] entries;
      logic [POS_W-1:0]                   length;
   } rotary_cfg_type;

   // One rotary step request
   typedef struct packed {
      logic                       feed;
      entry_kind_type             kind;
      logic [CODE_W-1:0]          code;
      logic signed [VALUE_W-1:0]  value;
      logic [POS_W-1:0]           index;
   } rotary_step_type;

   typedef struct packed {
      logic [POS_W-1:0] index;
      logic             fired;
   } rotary_result_type;

   // Clamp a programmed length into 1..max
   function automatic logic [POS_W-1:0] eff_len(input logic [POS_W-1:0] len,
                                                input logic [POS_W-1:0] max_len);
      logic [POS_W-1:0] res;
      if (len == '0) begin
         res = POS_W'(1);
      end else if (len > max_len) begin
         res = max_len;
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/kcsd_if.sv -----
`timescale 1ns / 1ps

// Input event channel
interface kcsd_req_if;
   import kcsd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [CODE_W-1:0]         code;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, action, code, value, input ready);
   modport sink   (input valid, action, code, value, output ready);
endinterface

// Result channel
interface kcsd_rsp_if;
   import kcsd_pkg::*;

   logic             valid;
   logic             ready;
   logic             combo_fired;
   logic             hold_fired;
   logic             rotary_fired;
   logic             hold_armed;
   logic [POS_W-1:0] combo_position;
   logic [POS_W-1:0] rotary_position;

   modport source (output valid, combo_fired, hold_fired, rotary_fired, hold_armed,
                   combo_position, rotary_position, input ready);
   modport sink   (input valid, combo_fired, hold_fired, rotary_fired, hold_armed,
                   combo_position, rotary_position, output ready);
endinterface

// ----- hw/rtl/kcsd_rotary.sv -----
`timescale 1ns / 1ps

module kcsd_rotary
   import kcsd_pkg::*;
(
   input  rotary_cfg_type    cfg,
   input  rotary_step_type   step,
   output rotary_result_type result
);

   logic [ENTRY_W-1:0] entry;
   entry_kind_type     entry_kind;
   logic [CODE_W-1:0]  entry_code;
   logic [POS_W-1:0]   next_pos;
   logic               value_fits;

   // Pick the entry at the current position
   assign entry      = cfg.entries[step.index];
   assign entry_kind = entry_kind_type'(entry[ENTRY_W-1]);
   assign entry_code = entry[CODE_W-1:0];
   assign next_pos   = step.index + POS_W'(1);

   // Power key value must be non-negative and below the length
   assign value_fits = !step.value[VALUE_W-1] &&
                       ($unsigned(step.value) < VALUE_W'(cfg.length));

   always_comb begin
      result.index = step.index;
      result.fired = 1'b0;
      if (step.feed) begin
         if (step.index >= cfg.length) begin
            result.index = '0;
         end else if (entry_kind != step.kind) begin
            result.index = '0;
         end else if (step.kind == KIND_KEY) begin
            // Key entry: jump to the position carried in the value
            if (entry_code == step.code && value_fits) begin
               result.index = step.value[POS_W-1:0];
            end else begin
               result.index = '0;
            end
         end else if (entry_code == step.code) begin
            // Motion entry matched: advance, fire at the end
            if (next_pos >= cfg.length) begin
               result.index = '0;
               result.fired = 1'b1;
            end else begin
               result.index = next_pos;
            end
         end else if (step.code != AXIS_X) begin
            result.index = '0;
         end
      end
   end

endmodule

// ----- hw/rtl/key_combo_sequence_detector.sv -----
`timescale 1ns / 1ps
// Detects a key combo, a long key press and a mixed key/rotary gesture in a
// stream of events, and returns one result item per event item. An event is
// taken in every cycle; its result appears in the next cycle from the single
// result register, and the event channel stalls only while that register
// holds a result the sink has not taken. Configuration writes apply on the
// clock edge of the write and are meant for idle periods.
`include "key_combo_sequence_detector_defines.svh"

module key_combo_sequence_detector
   import kcsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   kcsd_req_if.sink              req_ch,
   kcsd_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [COMBO_MAX-1:0][CODE_W-1:0]    combo_codes_ff;
   logic [POS_W-1:0]                    combo_length_ff;
   logic [ROTARY_MAX-1:0][ENTRY_W-1:0]  rotary_entries_ff;
   logic [POS_W-1:0]                    rotary_length_ff;
   logic [CODE_W-1:0]                   hold_key_code_ff;
   logic [HOLD_VALUE_W-1:0]             hold_key_value_ff;
   logic [HOLD_TICKS_W-1:0]             hold_ticks_ff;
   logic                                count_repeats_ff;

   // Detector state
   logic [POS_W-1:0]      combo_index_ff, combo_index_in;
   logic [POS_W-1:0]      rotary_index_ff;
   logic                  hold_enabled_ff, hold_enabled_in;
   logic [TIMER_BITS-1:0] countdown_ff, countdown_in;

   // Result register
   logic             rsp_valid_ff;
   logic             combo_fired_ff, combo_fired_in;
   logic             hold_fired_ff, hold_fired_in;
   logic             rotary_fired_ff;
   logic [POS_W-1:0] combo_pos_ff;
   logic [POS_W-1:0] rotary_pos_ff;

   logic              accept;
   action_type        action;
   logic [POS_W-1:0]  combo_len;
   logic [CODE_W-1:0] combo_entry;
   logic [POS_W-1:0]  combo_next;
   logic              combo_feed;
   logic              hold_match;
   logic [31:0]       ticks_wide;
   logic [31:0]       ticks_sat;
   rotary_cfg_type    rot_cfg;
   rotary_step_type   rot_step;
   rotary_result_type rot_result;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign action       = action_type'(req_ch.action);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         combo_codes_ff    <= '0;
         combo_length_ff   <= POS_W'(1);
         rotary_entries_ff <= '0;
         rotary_length_ff  <= POS_W'(1);
         hold_key_code_ff  <= '0;
         hold_key_value_ff <= HOLD_VALUE_W'(1);
         hold_ticks_ff     <= HOLD_TICKS_RESET;
         count_repeats_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COMBO_CODES:    combo_codes_ff    <= csr_wdata[COMBO_MAX*CODE_W-1:0];
            CSR_COMBO_LENGTH:   combo_length_ff   <= csr_wdata[POS_W-1:0];
            CSR_ROTARY_ENTRIES: rotary_entries_ff <= csr_wdata[ROTARY_MAX*ENTRY_W-1:0];
            CSR_ROTARY_LENGTH:  rotary_length_ff  <= csr_wdata[POS_W-1:0];
            CSR_HOLD_KEY_CODE:  hold_key_code_ff  <= csr_wdata[CODE_W-1:0];
            CSR_HOLD_KEY_VALUE: hold_key_value_ff <= csr_wdata[HOLD_VALUE_W-1:0];
            CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_wdata[HOLD_TICKS_W-1:0];
            CSR_COUNT_REPEATS:  count_repeats_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Step the combo matcher
   assign combo_len   = eff_len(combo_length_ff, POS_W'(COMBO_MAX));
   assign combo_entry = combo_codes_ff[combo_index_ff];
   assign combo_next  = combo_index_ff + POS_W'(1);
   assign combo_feed  = (action == ACT_KEY) &&
                        (req_ch.value[0] || (count_repeats_ff && req_ch.value[1]));

   always_comb begin
      combo_index_in = combo_index_ff;
      combo_fired_in = 1'b0;
      if (combo_feed) begin
         if (combo_index_ff >= combo_len) begin
            combo_index_in = '0;
         end else if (combo_entry == req_ch.code) begin
            if (combo_next >= combo_len) begin
               combo_index_in = '0;
               combo_fired_in = 1'b1;
            end else begin
               combo_index_in = combo_next;
            end
         end else if (combo_codes_ff[0] == req_ch.code) begin
            combo_index_in = POS_W'(1);
         end else begin
            combo_index_in = '0;
         end
      end
   end

   // Reload, disarm and count down the hold gesture
   assign hold_match = (req_ch.code == hold_key_code_ff) &&
                       (req_ch.value == $signed(VALUE_W'(hold_key_value_ff)));
   assign ticks_wide = 32'(hold_ticks_ff);
   assign ticks_sat  = (ticks_wide > TIMER_LIMIT) ? TIMER_LIMIT : ticks_wide;

   always_comb begin
      hold_enabled_in = hold_enabled_ff;
      countdown_in    = countdown_ff;
      hold_fired_in   = 1'b0;
      case (action)
         ACT_KEY: begin
            if (hold_enabled_ff) begin
               if (hold_match) begin
                  countdown_in = TIMER_BITS'(ticks_sat);
               end else begin
                  hold_enabled_in = 1'b0;
               end
            end
         end
         ACT_TICK: begin
            if (countdown_ff != '0) begin
               countdown_in  = countdown_ff - TIMER_BITS'(1);
               hold_fired_in = (countdown_ff == TIMER_BITS'(1)) && hold_enabled_ff;
            end
         end
         default: ;
      endcase
   end

   // Step the rotary matcher
   assign rot_cfg.entries = rotary_entries_ff;
   assign rot_cfg.length  = eff_len(rotary_length_ff, POS_W'(ROTARY_MAX));
   assign rot_step.feed   = (action == ACT_REL) ||
                            ((action == ACT_KEY) && (req_ch.code == POWER_KEY_CODE));
   assign rot_step.kind   = (action == ACT_REL) ? KIND_REL : KIND_KEY;
   assign rot_step.code   = req_ch.code;
   assign rot_step.value  = req_ch.value;
   assign rot_step.index  = rotary_index_ff;

   kcsd_rotary u_rotary (
      .cfg    (rot_cfg),
      .step   (rot_step),
      .result (rot_result)
   );

   // Advance state on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         combo_index_ff  <= '0;
         rotary_index_ff <= '0;
         hold_enabled_ff <= 1'b1;
         countdown_ff    <= '0;
      end else if (accept) begin
         combo_index_ff  <= combo_index_in;
         rotary_index_ff <= rot_result.index;
         hold_enabled_ff <= hold_enabled_in;
         countdown_ff    <= countdown_in;
      end
   end

   // Hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         combo_fired_ff  <= combo_fired_in;
         hold_fired_ff   <= hold_fired_in;
         rotary_fired_ff <= rot_result.fired;
         combo_pos_ff    <= combo_index_in;
         rotary_pos_ff   <= rot_result.index;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.combo_fired     = combo_fired_ff;
   assign rsp_ch.hold_fired      = hold_fired_ff;
   assign rsp_ch.rotary_fired    = rotary_fired_ff;
   assign rsp_ch.hold_armed      = hold_enabled_ff;
   assign rsp_ch.combo_position  = combo_pos_ff;
   assign rsp_ch.rotary_position = rotary_pos_ff;

   // Positions stay inside their sequences
   `KCSD_ASSERT_ALWAYS(a_combo_pos, combo_index_ff < POS_W'(COMBO_MAX), "bad combo pos")
   `KCSD_ASSERT_ALWAYS(a_rotary_pos, rotary_index_ff < POS_W'(ROTARY_MAX), "bad rotary pos")
   // Once disarmed, the hold gesture stays disarmed
   `KCSD_ASSERT_NEXT(a_hold_sticky, !hold_enabled_ff, !hold_enabled_ff, "hold gesture rearmed")
   // A hold report only comes while armed
   `KCSD_ASSERT_ALWAYS(a_hold_fire, !rsp_valid_ff || !hold_fired_ff || hold_enabled_ff, "bad fire")
   // Every accepted item leaves a result
   `KCSD_ASSERT_NEXT(a_accept_result, accept, rsp_valid_ff, "accepted item lost its result")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import kcsd_pkg::*;

   localparam int STALL_PCT    = 11;
   localparam int IDLE_LIMIT   = 2000;
   localparam int EVENT_TARGET = 800;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      action_type                action;
      logic [CODE_W-1:0]         code;
      logic signed [VALUE_W-1:0] value;
   } key_event_t;

   typedef struct packed {
      logic             combo_fired;
      logic             hold_fired;
      logic             rotary_fired;
      logic             hold_armed;
      logic [POS_W-1:0] combo_position;
      logic [POS_W-1:0] rotary_position;
   } gesture_flags_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kcsd_req_if req_bus ();
   kcsd_rsp_if rsp_bus ();

   key_combo_sequence_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies, reset values
   logic [COMBO_MAX*CODE_W-1:0]    set_combo_codes    = '0;
   logic [POS_W-1:0]               set_combo_length   = POS_W'(1);
   logic [ROTARY_MAX*ENTRY_W-1:0]  set_rotary_entries = '0;
   logic [POS_W-1:0]               set_rotary_length  = POS_W'(1);
   logic [CODE_W-1:0]              set_hold_code      = '0;
   logic [HOLD_VALUE_W-1:0]        set_hold_value     = HOLD_VALUE_W'(1);
   logic [HOLD_TICKS_W-1:0]        set_hold_ticks     = HOLD_TICKS_RESET;
   logic                           set_count_repeats  = 1'b0;

   // Gesture state, reset values
   logic [POS_W-1:0]      combo_pos  = '0;
   logic [POS_W-1:0]      rotary_pos = '0;
   logic                  hold_armed = 1'b1;
   logic [TIMER_BITS-1:0] hold_count = '0;

   key_event_t     event_queue[$];
   gesture_flags_t due_flags[$];

   int fault_count = 0;
   int idle_cycles = 0;
   int event_count = 0;
   bit req_taken   = 1'b0;
   bit calm        = 1'b0;

   always #2 clock = ~clock;

   // Clamp a programmed length into 1..top
   function automatic int seq_span(logic [POS_W-1:0] len, int top);
      if (len == '0) return 1;
      if (len > top) return top;
      return len;
   endfunction

   // Advance the dump combo with one key code; return 1 when it completes
   function automatic logic step_combo(logic [CODE_W-1:0] code);
      int                span;
      logic [CODE_W-1:0] want_code;
      span = seq_span(set_combo_length, COMBO_MAX);
      if (combo_pos >= span) begin
         combo_pos = '0;
         return 1'b0;
      end
      want_code = set_combo_codes[combo_pos*CODE_W +: CODE_W];
      if (want_code == code) begin
         if (combo_pos + 1 >= span) begin
            combo_pos = '0;
            return 1'b1;
         end
         combo_pos = combo_pos + 1'b1;
      end else if (set_combo_codes[CODE_W-1:0] == code) begin
         combo_pos = POS_W'(1);
      end else begin
         combo_pos = '0;
      end
      return 1'b0;
   endfunction

   // Advance the rotary sequence; return 1 when it completes
   function automatic logic step_rotary(entry_kind_type kind, logic [CODE_W-1:0] code,
                                        int sval);
      int                 span;
      logic [ENTRY_W-1:0] entry;
      span = seq_span(set_rotary_length, ROTARY_MAX);
      if (rotary_pos >= span) begin
         rotary_pos = '0;
         return 1'b0;
      end
      entry = set_rotary_entries[rotary_pos*ENTRY_W +: ENTRY_W];
      if (entry[ENTRY_W-1] != kind) begin
         rotary_pos = '0;
         return 1'b0;
      end
      // power key jumps to the position its value names
      if (kind == KIND_KEY) begin
         if (entry[CODE_W-1:0] == code && sval >= 0 && sval < span) begin
            rotary_pos = POS_W'(sval);
         end else begin
            rotary_pos = '0;
         end
         return 1'b0;
      end
      if (entry[CODE_W-1:0] == code) begin
         if (rotary_pos + 1 >= span) begin
            rotary_pos = '0;
            return 1'b1;
         end
         rotary_pos = rotary_pos + 1'b1;
      end else if (code != AXIS_X) begin
         rotary_pos = '0;
      end
      return 1'b0;
   endfunction

   // Apply one event to the gesture state and return its flags
   function automatic gesture_flags_t detect_gestures(key_event_t ev);
      gesture_flags_t res;
      int             sval;
      res  = '0;
      sval = int'($signed(ev.value));
      case (ev.action)
         ACT_KEY: begin
            if (ev.value[0] || (set_count_repeats && ev.value[1])) begin
               res.combo_fired = step_combo(ev.code);
            end
            if (hold_armed) begin
               if (ev.code != set_hold_code || sval != int'(set_hold_value)) begin
                  hold_armed = 1'b0;
               end else begin
                  hold_count = set_hold_ticks;
               end
            end
            if (ev.code == POWER_KEY_CODE) begin
               res.rotary_fired = step_rotary(KIND_KEY, ev.code, sval);
            end
         end
         ACT_REL: begin
            res.rotary_fired = step_rotary(KIND_REL, ev.code, sval);
         end
         ACT_TICK: begin
            if (hold_count != '0) begin
               hold_count = hold_count - 1'b1;
               if (hold_count == '0 && hold_armed) res.hold_fired = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.hold_armed      = hold_armed;
      res.combo_position  = combo_pos;
      res.rotary_position = rotary_pos;
      return res;
   endfunction

   // Present the next item and drive the result ready
   always @(negedge clock) begin : drive_events
      key_event_t ev;
      if (!req_bus.valid || req_taken) begin
         if (event_queue.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
            ev = event_queue.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.action <= ev.action;
            req_bus.code   <= ev.code;
            req_bus.value  <= ev.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= calm || ($urandom_range(99) >= STALL_PCT);
   end

   // Check results, then predict for the item taken at this edge
   always @(posedge clock) begin : watch_results
      key_event_t     ev;
      gesture_flags_t got;
      gesture_flags_t want;
      if (reset) begin
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.combo_fired     = rsp_bus.combo_fired;
            got.hold_fired      = rsp_bus.hold_fired;
            got.rotary_fired    = rsp_bus.rotary_fired;
            got.hold_armed      = rsp_bus.hold_armed;
            got.combo_position  = rsp_bus.combo_position;
            got.rotary_position = rsp_bus.rotary_position;
            if (due_flags.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_MAX) begin
                  $display("unexpected result item at %0t", $realtime);
               end
            end else begin
               want = due_flags.pop_front();
               if (got.combo_fired !== want.combo_fired ||
                   got.hold_fired !== want.hold_fired ||
                   got.rotary_fired !== want.rotary_fired ||
                   got.hold_armed !== want.hold_armed ||
                   got.combo_position !== want.combo_position ||
                   got.rotary_position !== want.rotary_position) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX) begin
                     $display(
                        "mismatch at %0t: expected cf=%0d hf=%0d rf=%0d arm=%0d cpos=%0d rpos=%0d",
                        $realtime, want.combo_fired, want.hold_fired,
                        want.rotary_fired, want.hold_armed,
                        want.combo_position, want.rotary_position);
                     $display(
                        "              actual   cf=%0d hf=%0d rf=%0d arm=%0d cpos=%0d rpos=%0d",
                        got.combo_fired, got.hold_fired, got.rotary_fired,
                        got.hold_armed, got.combo_position, got.rotary_position);
                  end
               end
            end
         end
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            ev.action = action_type'(req_bus.action);
            ev.code   = req_bus.code;
            ev.value  = req_bus.value;
            due_flags.push_back(detect_gestures(ev));
         end
         // watchdog on handshake progress
         if (req_taken || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("key_combo_sequence_detector test failed");
            $finish;
         end
      end
   end

   task automatic push_event(action_type act, logic [CODE_W-1:0] code,
                             logic [VALUE_W-1:0] value);
      key_event_t ev;
      ev.action = act;
      ev.code   = code;
      ev.value  = value;
      event_queue.push_back(ev);
      if (act != ACT_OTHER) event_count++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_COMBO_CODES:    set_combo_codes    = data[COMBO_MAX*CODE_W-1:0];
         CSR_COMBO_LENGTH:   set_combo_length   = data[POS_W-1:0];
         CSR_ROTARY_ENTRIES: set_rotary_entries = data[ROTARY_MAX*ENTRY_W-1:0];
         CSR_ROTARY_LENGTH:  set_rotary_length  = data[POS_W-1:0];
         CSR_HOLD_KEY_CODE:  set_hold_code      = data[CODE_W-1:0];
         CSR_HOLD_KEY_VALUE: set_hold_value     = data[HOLD_VALUE_W-1:0];
         CSR_HOLD_TICKS:     set_hold_ticks     = data[HOLD_TICKS_W-1:0];
         CSR_COUNT_REPEATS:  set_count_repeats  = data[0];
         default: begin
         end
      endcase
   endtask

   // Program every register, then release the port
   task automatic load_setup(logic [COMBO_MAX*CODE_W-1:0] codes, logic [POS_W-1:0] combo_len,
                             logic [ROTARY_MAX*ENTRY_W-1:0] entries,
                             logic [POS_W-1:0] rotary_len, logic [CODE_W-1:0] hold_code,
                             logic [HOLD_VALUE_W-1:0] hold_value,
                             logic [HOLD_TICKS_W-1:0] ticks, logic repeats);
      write_reg(CSR_COMBO_CODES, CSR_DATA_W'(codes));
      write_reg(CSR_COMBO_LENGTH, CSR_DATA_W'(combo_len));
      write_reg(CSR_ROTARY_ENTRIES, CSR_DATA_W'(entries));
      write_reg(CSR_ROTARY_LENGTH, CSR_DATA_W'(rotary_len));
      write_reg(CSR_HOLD_KEY_CODE, CSR_DATA_W'(hold_code));
      write_reg(CSR_HOLD_KEY_VALUE, CSR_DATA_W'(hold_value));
      write_reg(CSR_HOLD_TICKS, CSR_DATA_W'(ticks));
      write_reg(CSR_COUNT_REPEATS, CSR_DATA_W'(repeats));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every pending item and result has gone through
   task automatic drain();
      while (event_queue.size() != 0 || req_bus.valid || due_flags.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [COMBO_MAX*CODE_W-1:0] draw_combo_codes();
      logic [COMBO_MAX*CODE_W-1:0] codes;
      case ($urandom_range(9))
         0: codes = '1;
         1: codes = '0;
         default: codes = (COMBO_MAX*CODE_W)'({$urandom, $urandom});
      endcase
      return codes;
   endfunction

   function automatic logic [ROTARY_MAX*ENTRY_W-1:0] draw_rotary_entries();
      logic [ROTARY_MAX*ENTRY_W-1:0] all;
      entry_kind_type                kind;
      logic [CODE_W-1:0]             code;
      if ($urandom_range(11) == 0) return '1;
      if ($urandom_range(11) == 0) return '0;
      for (int i = 0; i < ROTARY_MAX; i++) begin
         kind = entry_kind_type'($urandom_range(1));
         if (kind == KIND_KEY) begin
            code = ($urandom_range(4) != 0) ? POWER_KEY_CODE : CODE_W'($urandom);
         end else begin
            code = ($urandom_range(9) == 0) ? AXIS_X : CODE_W'($urandom_range(1, 1023));
         end
         all[i*ENTRY_W +: ENTRY_W] = {kind, code};
      end
      return all;
   endfunction

   function automatic logic [POS_W-1:0] draw_length(int top);
      case ($urandom_range(9))
         0: return '0;
         1: return POS_W'(7);
         2: return POS_W'(1);
         3: return POS_W'(top);
         default: return POS_W'($urandom_range(1, top));
      endcase
   endfunction

   // Random event, biased toward the configured codes
   task automatic add_noise();
      action_type        act;
      logic [CODE_W-1:0] code;
      logic [VALUE_W-1:0] value;
      act = action_type'($urandom_range(3));
      case ($urandom_range(3))
         0: code = set_combo_codes[$urandom_range(COMBO_MAX-1)*CODE_W +: CODE_W];
         1: code = (act == ACT_REL) ?
                   set_rotary_entries[$urandom_range(ROTARY_MAX-1)*ENTRY_W +: CODE_W] :
                   POWER_KEY_CODE;
         2: code = AXIS_X;
         default: code = CODE_W'($urandom);
      endcase
      value = ($urandom_range(3) == 0) ? VALUE_W'($urandom_range(3)) : VALUE_W'($urandom);
      push_event(act, code, value);
   endtask

   // Walk the whole combo with presses, with stray releases and noise
   task automatic add_combo_run();
      int                 span;
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] press;
      span = seq_span(set_combo_length, COMBO_MAX);
      for (int i = 0; i < span; i++) begin
         code  = set_combo_codes[i*CODE_W +: CODE_W];
         press = (set_count_repeats && $urandom_range(1)) ? VALUE_W'(2) : VALUE_W'(1);
         if ($urandom_range(7) == 0) push_event(ACT_KEY, code, '0);
         if ($urandom_range(15) == 0) add_noise();
         push_event(ACT_KEY, code, press);
      end
   endtask

   // Walk the rotary sequence, power key mostly naming the next position
   task automatic add_rotary_run();
      int                 span;
      logic [ENTRY_W-1:0] entry;
      span = seq_span(set_rotary_length, ROTARY_MAX);
      for (int p = 0; p < span; p++) begin
         entry = set_rotary_entries[p*ENTRY_W +: ENTRY_W];
         if ($urandom_range(7) == 0) push_event(ACT_REL, AXIS_X, VALUE_W'($urandom));
         if (entry[ENTRY_W-1] == KIND_KEY) begin
            push_event(ACT_KEY, POWER_KEY_CODE,
                       ($urandom_range(9) < 8) ? VALUE_W'(p + 1) : VALUE_W'($urandom));
         end else begin
            push_event(ACT_REL, entry[CODE_W-1:0], VALUE_W'($urandom));
         end
      end
   endtask

   task automatic add_random_mix(int quota);
      int start;
      start = event_count;
      while (event_count - start < quota) begin
         case ($urandom_range(9))
            0, 1, 2, 3: add_combo_run();
            4, 5, 6:    add_rotary_run();
            default:    repeat ($urandom_range(1, 4)) add_noise();
         endcase
      end
   endtask

   initial begin : stimulus
      logic [CODE_W-1:0]             hold_key;
      logic [CODE_W-1:0]             rel_a;
      logic [CODE_W-1:0]             rel_b;
      logic [CODE_W-1:0]             picks[COMBO_MAX];
      logic [COMBO_MAX*CODE_W-1:0]   codes;
      logic [ROTARY_MAX*ENTRY_W-1:0] rot;
      logic [HOLD_TICKS_W-1:0]       ticks;
      bit                            clash;
      int                            round;

      req_bus.valid  = 1'b0;
      req_bus.action = ACT_KEY;
      req_bus.code   = '0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_COMBO_CODES;
      csr_wdata      = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pick distinct combo codes apart from the power and hold keys
      hold_key = CODE_W'($urandom);
      while (hold_key == POWER_KEY_CODE) hold_key = CODE_W'($urandom);
      for (int i = 0; i < COMBO_MAX; i++) begin
         clash = 1'b1;
         while (clash) begin
            picks[i] = CODE_W'($urandom);
            clash = (picks[i] == POWER_KEY_CODE) || (picks[i] == hold_key);
            for (int j = 0; j < i; j++) begin
               if (picks[j] == picks[i]) clash = 1'b1;
            end
         end
         codes[i*CODE_W +: CODE_W] = picks[i];
      end
      rel_a = CODE_W'($urandom_range(1, 1023));
      rel_b = CODE_W'($urandom_range(1, 1023));
      rot = draw_rotary_entries();
      rot[0*ENTRY_W +: ENTRY_W] = {KIND_REL, rel_a};
      rot[1*ENTRY_W +: ENTRY_W] = {KIND_KEY, POWER_KEY_CODE};
      rot[2*ENTRY_W +: ENTRY_W] = {KIND_REL, rel_b};

      // Hold gesture while armed: expire, reload, ignored event, X axis idle
      load_setup(codes, 3, rot, 3, hold_key, 1, 3, 0);
      push_event(ACT_OTHER, CODE_W'($urandom), VALUE_W'($urandom));
      push_event(ACT_KEY, hold_key, 1);
      repeat (3) push_event(ACT_TICK, CODE_W'($urandom), VALUE_W'($urandom));
      push_event(ACT_REL, AXIS_X, VALUE_W'($urandom));
      push_event(ACT_REL, rel_a, VALUE_W'($urandom));
      push_event(ACT_KEY, hold_key, 1);
      drain();

      // Reload with zero ticks stops a running countdown
      load_setup(codes, 3, rot, 3, hold_key, 1, 0, 0);
      push_event(ACT_TICK, '0, '0);
      push_event(ACT_KEY, hold_key, 1);
      push_event(ACT_TICK, '0, '0);
      push_event(ACT_TICK, '1, '1);
      drain();

      // One-tick hold on release events, still armed throughout
      load_setup(codes, 3, rot, 3, hold_key, 0, 1, 0);
      repeat (40) begin
         case ($urandom_range(9))
            0, 1, 2, 3: push_event(ACT_KEY, hold_key, '0);
            4, 5, 6, 7: push_event(ACT_TICK, CODE_W'($urandom), VALUE_W'($urandom));
            default:    push_event(ACT_OTHER, CODE_W'($urandom), VALUE_W'($urandom));
         endcase
      end
      drain();

      // Disarm on the power key, finish rotary and combo, restart on first code
      load_setup(codes, 3, rot, 3, hold_key, 3, 16'hFFFF, 0);
      push_event(ACT_KEY, hold_key, 3);
      push_event(ACT_TICK, '0, '0);
      push_event(ACT_KEY, POWER_KEY_CODE, 2);
      push_event(ACT_TICK, '0, '0);
      push_event(ACT_REL, rel_b, VALUE_W'($urandom));
      for (int i = 0; i < 3; i++) push_event(ACT_KEY, picks[i], 1);
      push_event(ACT_KEY, picks[0], 1);
      push_event(ACT_KEY, picks[1], 1);
      push_event(ACT_KEY, picks[0], 1);
      push_event(ACT_KEY, picks[1], 1);
      push_event(ACT_KEY, picks[2], 1);
      drain();

      // Longest sequences, left part way through
      load_setup(draw_combo_codes(), COMBO_MAX, draw_rotary_entries(), ROTARY_MAX,
                 hold_key, 2, 16'd1, 1);
      add_random_mix(50);
      for (int i = 0; i < 4; i++) begin
         push_event(ACT_KEY, set_combo_codes[i*CODE_W +: CODE_W], 1);
      end
      drain();

      // Zero lengths act as one; stale positions drop to zero
      load_setup(draw_combo_codes(), 0, draw_rotary_entries(), 0, '0, 0, 16'd1, 0);
      push_event(ACT_KEY, CODE_W'($urandom), 1);
      push_event(ACT_REL, CODE_W'($urandom), VALUE_W'($urandom));
      add_random_mix(40);
      drain();

      // Lengths above the maximum
      load_setup(draw_combo_codes(), 7, draw_rotary_entries(), 7, '1, 2, 16'd0, 1);
      add_random_mix(40);
      drain();

      // Random setups until the item budget is spent
      round = 0;
      while (event_count < EVENT_TARGET) begin
         case ($urandom_range(3))
            0: ticks = '0;
            1: ticks = 16'd1;
            2: ticks = '1;
            default: ticks = HOLD_TICKS_W'($urandom);
         endcase
         load_setup(draw_combo_codes(), draw_length(COMBO_MAX), draw_rotary_entries(),
                    draw_length(ROTARY_MAX), CODE_W'($urandom),
                    HOLD_VALUE_W'($urandom_range(3)), ticks, $urandom_range(1));
         calm = (round == 2);
         add_random_mix(calm ? 150 : $urandom_range(40, 90));
         drain();
         calm = 1'b0;
         round++;
      end

      drain();
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("key_combo_sequence_detector test passed");
      end else begin
         $display("key_combo_sequence_detector test failed");
      end
      $finish;
   end

endmodule
